// ===== sv/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator package
// Shared types, constants and register codes for the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

    localparam int MaxSlabs   = 16;
    localparam int MaxObjects = 64;
    localparam int SlabShift  = 16;

    localparam int SlabW  = (MaxSlabs > 1) ? $clog2(MaxSlabs) : 1;
    localparam int ObjW   = (MaxObjects > 1) ? $clog2(MaxObjects) : 1;
    localparam int CntW   = $clog2(MaxObjects + 1);
    localparam int GrownW = $clog2(MaxSlabs + 1);
    localparam int MemW   = SlabW + ObjW;
    localparam int AddrW  = 48;
    localparam int StampW = 64;

    localparam logic [1:0] CLS_UNUSED  = 2'd0;
    localparam logic [1:0] CLS_FREE    = 2'd1;
    localparam logic [1:0] CLS_PARTIAL = 2'd2;
    localparam logic [1:0] CLS_FULL    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLAB = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_DOUBLE  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] REG_OBJ_BYTES = 2'd0;
    localparam logic [1:0] REG_OBJ_COUNT = 2'd1;
    localparam logic [1:0] REG_BASE      = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [AddrW-1:0]  free_address;
    } t_in_word;

    typedef struct packed {
        logic [AddrW-1:0]  object_address;
        logic [1:0]        status;
    } t_out_word;

    typedef struct packed {
        logic [12:0]       object_bytes;
        logic [CntW-1:0]   eff_count;
        logic [AddrW-1:0]  region_base;
    } t_cfg;

endpackage

// ===== sv/slab_object_allocator.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator
// Sequenced allocate and free of fixed-size objects over a set of slabs.
// ----------------------------------------------------------------------------
// A command word is taken when i_start is high and o_busy is low. Operation
// zero allocates an object, operation one frees the object at free_address.
// Exactly one result word follows, shown for one cycle with o_done high; the
// receiver cannot stall it. The APB-style port sets the object size, the
// object count and the region base, and the user must write it only while
// idle; the block does not enforce this. One sequencer walks the slab table,
// one slab a cycle. An allocation scans, picks a slab, fills the stack of a
// newly grown slab when none is usable, then pops an offset. A free checks
// the slab, multiplies count by object size for the range check and pushes
// the offset. The result word is shown in the first idle cycle. After reset
// all slabs are unused, no slab is grown and the registers hold their
// defaults; the block can take a command in the next cycle.
// ----------------------------------------------------------------------------
module slab_object_allocator (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  soa_pkg::t_in_word       i_cmd,
    output logic                    o_done,
    output soa_pkg::t_out_word      o_result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [63:0]             pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);
    import soa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_PICK   = 4'd2;
    localparam logic [3:0] S_FILL   = 4'd3;
    localparam logic [3:0] S_POP    = 4'd4;
    localparam logic [3:0] S_READ   = 4'd5;
    localparam logic [3:0] S_OUT    = 4'd6;
    localparam logic [3:0] S_FCHK   = 4'd7;
    localparam logic [3:0] S_FMUL   = 4'd8;
    localparam logic [3:0] S_FPUSH  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    t_cfg cfg;

    soa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [3:0]        r_state;
    logic [CntW-1:0]   r_count [MaxSlabs];
    logic [1:0]        r_class [MaxSlabs];
    logic [StampW-1:0] r_stamp [MaxSlabs];
    logic [StampW-1:0] r_stamp_ctr;
    logic [GrownW-1:0] r_grown;
    logic [GrownW-1:0] r_idx;
    logic              r_p_hit;
    logic [SlabW-1:0]  r_p_slab;
    logic [StampW-1:0] r_p_stamp;
    logic              r_f_hit;
    logic [SlabW-1:0]  r_f_slab;
    logic [StampW-1:0] r_f_stamp;
    logic [SlabW-1:0]  r_sel;
    logic [CntW-1:0]   r_k;
    logic [15:0]       r_koff;
    logic [AddrW-1:0]  r_rel;
    logic              r_ge;
    logic [19:0]       r_lim;
    logic [AddrW-1:0]  r_addr;
    logic [1:0]        r_status;
    logic              r_done;

    logic              we;
    logic [MemW-1:0]   waddr;
    logic [15:0]       wdata;
    logic [MemW-1:0]   raddr;
    logic [15:0]       rdata;

    soa_stack_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    logic [SlabW-1:0]  scan_i;
    logic [SlabW-1:0]  g_slab;
    logic [AddrW-1:0]  idx_full;
    logic [SlabW-1:0]  fslab;
    logic [CntW-1:0]   cnt_sel;
    logic [CntW-1:0]   cnt_dec;
    logic [CntW-1:0]   cnt_inc;

    assign scan_i   = r_idx[SlabW-1:0];
    assign g_slab   = r_grown[SlabW-1:0];
    assign idx_full = r_rel >> SlabShift;
    assign fslab    = idx_full[SlabW-1:0];
    assign cnt_sel  = r_count[r_sel];
    assign cnt_dec  = cnt_sel - CntW'(1);
    assign cnt_inc  = cnt_sel + CntW'(1);

    always_comb begin
        we    = 1'b0;
        waddr = {r_sel, r_k[ObjW-1:0]};
        wdata = r_koff;
        raddr = {r_sel, cnt_sel[ObjW-1:0]};
        if (r_state == S_FILL)
            we = 1'b1;
        else if (r_state == S_FPUSH && r_ge && 32'(fslab) < 32'(r_grown)
                 && idx_full < AddrW'(MaxSlabs)
                 && {4'd0, r_rel[SlabShift-1:0]} < r_lim
                 && cnt_sel < cfg.eff_count) begin
            we    = 1'b1;
            waddr = {r_sel, cnt_sel[ObjW-1:0]};
            wdata = 16'(r_rel[SlabShift-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stamp_ctr <= '0;
            r_grown     <= '0;
            r_done      <= 1'b0;
            for (int i = 0; i < MaxSlabs; i++) begin
                r_count[i] <= '0;
                r_class[i] <= CLS_UNUSED;
                r_stamp[i] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_idx   <= '0;
                        r_p_hit <= 1'b0;
                        r_f_hit <= 1'b0;
                        r_rel   <= i_cmd.free_address - cfg.region_base;
                        r_ge    <= i_cmd.free_address >= cfg.region_base;
                        r_state <= (i_cmd.operation == OP_FREE) ? S_FCHK : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_class[scan_i] == CLS_PARTIAL &&
                        (!r_p_hit || r_stamp[scan_i] > r_p_stamp)) begin
                        r_p_hit   <= 1'b1;
                        r_p_slab  <= scan_i;
                        r_p_stamp <= r_stamp[scan_i];
                    end
                    if (r_class[scan_i] == CLS_FREE &&
                        (!r_f_hit || r_stamp[scan_i] > r_f_stamp)) begin
                        r_f_hit   <= 1'b1;
                        r_f_slab  <= scan_i;
                        r_f_stamp <= r_stamp[scan_i];
                    end
                    r_idx <= r_idx + GrownW'(1);
                    if (32'(r_idx) == MaxSlabs - 1)
                        r_state <= S_PICK;
                end
                S_PICK: begin
                    r_k    <= '0;
                    r_koff <= '0;
                    if (r_p_hit) begin
                        r_sel   <= r_p_slab;
                        r_state <= S_POP;
                    end else if (r_f_hit) begin
                        r_sel   <= r_f_slab;
                        r_state <= S_POP;
                    end else if (32'(r_grown) < MaxSlabs) begin
                        r_sel   <= g_slab;
                        r_state <= S_FILL;
                    end else begin
                        r_addr   <= '0;
                        r_status <= ST_NO_SLAB;
                        r_state  <= S_DONE;
                    end
                end
                S_FILL: begin
                    r_k    <= r_k + CntW'(1);
                    r_koff <= r_koff + 16'(cfg.object_bytes);
                    if (r_k + CntW'(1) == cfg.eff_count) begin
                        r_count[r_sel] <= cfg.eff_count;
                        r_grown        <= r_grown + GrownW'(1);
                        if (r_class[r_sel] != CLS_FREE) begin
                            r_class[r_sel] <= CLS_FREE;
                            r_stamp[r_sel] <= r_stamp_ctr + StampW'(1);
                            r_stamp_ctr    <= r_stamp_ctr + StampW'(1);
                        end
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_count[r_sel] <= cnt_dec;
                    r_state        <= S_READ;
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_addr <= cfg.region_base +
                              (AddrW'(r_sel) << SlabShift) + AddrW'(rdata);
                    r_status <= ST_OK;
                    if (r_class[r_sel] != ((cnt_sel == '0) ? CLS_FULL : CLS_PARTIAL)) begin
                        r_class[r_sel] <= (cnt_sel == '0) ? CLS_FULL : CLS_PARTIAL;
                        r_stamp[r_sel] <= r_stamp_ctr + StampW'(1);
                        r_stamp_ctr    <= r_stamp_ctr + StampW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_FCHK: begin
                    r_sel   <= fslab;
                    r_state <= S_FMUL;
                end
                S_FMUL: begin
                    r_lim   <= 20'(cfg.eff_count) * 20'(cfg.object_bytes);
                    r_state <= S_FPUSH;
                end
                S_FPUSH: begin
                    r_addr <= '0;
                    if (!(r_ge && 32'(fslab) < 32'(r_grown)
                          && idx_full < AddrW'(MaxSlabs)
                          && {4'd0, r_rel[SlabShift-1:0]} < r_lim
                          && r_class[r_sel] != CLS_UNUSED)) begin
                        r_status <= ST_BAD;
                    end else if (cnt_sel >= cfg.eff_count) begin
                        r_status <= ST_DOUBLE;
                    end else begin
                        r_status       <= ST_OK;
                        r_count[r_sel] <= cnt_inc;
                        if (r_class[r_sel] !=
                            ((cnt_inc >= cfg.eff_count) ? CLS_FREE : CLS_PARTIAL)) begin
                            r_class[r_sel] <= (cnt_inc >= cfg.eff_count) ?
                                              CLS_FREE : CLS_PARTIAL;
                            r_stamp[r_sel] <= r_stamp_ctr + StampW'(1);
                            r_stamp_ctr    <= r_stamp_ctr + StampW'(1);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy                  = (r_state != S_IDLE);
    assign o_done                  = r_done;
    assign o_result.object_address = r_addr;
    assign o_result.status         = r_status;

`ifndef ASSERT_OFF
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_grown_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_grown) <= MaxSlabs) else $error("grown count overflow");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("done while busy");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> cnt_sel != '0) else $error("pop from empty slab");
`endif

endmodule

// ===== sv/soa_cfg.sv =====
// ----------------------------------------------------------------------------
// Slab allocator configuration registers
// APB-style register port holding object size, object count and region base.
// ----------------------------------------------------------------------------
module soa_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output soa_pkg::t_cfg       o_cfg
);
    import soa_pkg::*;

    logic [12:0]      r_obj_bytes;
    logic [6:0]       r_obj_count;
    logic [AddrW-1:0] r_base;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_bytes <= 13'd64;
            r_obj_count <= 7'd64;
            r_base      <= '0;
        end else if (wr && paddr[2:0] == 3'd0) begin
            unique case (paddr[4:3])
                REG_OBJ_BYTES: r_obj_bytes <= pwdata[12:0];
                REG_OBJ_COUNT: r_obj_count <= pwdata[6:0];
                REG_BASE:      r_base      <= pwdata[AddrW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[4:3])
            REG_OBJ_BYTES: prdata = {51'd0, r_obj_bytes};
            REG_OBJ_COUNT: prdata = {57'd0, r_obj_count};
            REG_BASE:      prdata = {16'd0, r_base};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.object_bytes = r_obj_bytes;
        o_cfg.region_base  = r_base;
        if (r_obj_count == 7'd0)
            o_cfg.eff_count = CntW'(1);
        else if (32'(r_obj_count) > MaxObjects)
            o_cfg.eff_count = CntW'(MaxObjects);
        else
            o_cfg.eff_count = CntW'(r_obj_count);
    end

endmodule

// ===== sv/soa_stack_ram.sv =====
// ----------------------------------------------------------------------------
// Slab allocator offset stack memory
// One write port and one registered read port holding the free offset stacks.
// ----------------------------------------------------------------------------
module soa_stack_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [soa_pkg::MemW-1:0]    i_waddr,
    input  logic [15:0]                 i_wdata,
    input  logic [soa_pkg::MemW-1:0]    i_raddr,
    output logic [15:0]                 o_rdata
);
    import soa_pkg::*;

    logic [15:0] mem [MaxSlabs*MaxObjects];

    always_ff @(posedge i_clk) begin
        if (i_we)
            mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== bench/slab_object_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Slab object allocator testbench
// Drives allocate and free commands through several register settings and
// checks every result word against a behavioral allocator model.
// ----------------------------------------------------------------------------
module slab_object_allocator_tb;
    import soa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    t_in_word    cmd;
    logic        done;
    t_out_word   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    slab_object_allocator u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_cmd    (cmd),
        .o_done   (done),
        .o_result (result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    localparam int CycleLimit = 2000000;
    localparam int SettleCycles = MaxSlabs + MaxObjects + 16;

    // Model state.
    logic [15:0]       m_offsets [MaxSlabs*MaxObjects];
    int unsigned       m_count [MaxSlabs];
    logic [1:0]        m_class [MaxSlabs];
    longint unsigned   m_stamp [MaxSlabs];
    longint unsigned   m_stamp_ctr;
    int unsigned       m_grown;
    int unsigned       m_obj_bytes;
    int unsigned       m_obj_count;
    logic [AddrW-1:0]  m_base;

    t_out_word   expected_words [$];
    int          mismatches;
    int          fails;
    longint      cycles;

    // Addresses handed out and not yet freed, for well-formed frees.
    logic [AddrW-1:0] live_addrs [$];

    typedef struct {
        t_in_word  word;
        logic      has_exp;
        t_out_word exp;
    } t_row;

    function automatic int unsigned eff_count();
        if (m_obj_count < 1) return 1;
        if (m_obj_count > MaxObjects) return MaxObjects;
        return m_obj_count;
    endfunction

    function automatic void set_class(int s, logic [1:0] c);
        if (m_class[s] != c) begin
            m_class[s] = c;
            m_stamp_ctr++;
            m_stamp[s] = m_stamp_ctr;
        end
    endfunction

    function automatic int newest_slab(logic [1:0] c);
        int best;
        best = -1;
        for (int s = 0; s < MaxSlabs; s++) begin
            if (m_class[s] == c && (best < 0 || m_stamp[s] > m_stamp[best])) begin
                best = s;
            end
        end
        return best;
    endfunction

    function automatic t_out_word predict_allocator(t_in_word w);
        t_out_word r;
        int unsigned n;
        int s;
        logic [AddrW-1:0] rel;
        longint unsigned idx;
        longint unsigned off;
        n = eff_count();
        r = '0;
        if (w.operation == OP_ALLOC) begin
            s = newest_slab(CLS_PARTIAL);
            if (s < 0) s = newest_slab(CLS_FREE);
            if (s < 0 && m_grown < MaxSlabs) begin
                s = m_grown;
                m_grown++;
                for (int k = 0; k < n; k++) begin
                    m_offsets[s*MaxObjects+k] = 16'((k * m_obj_bytes) & 16'hFFFF);
                end
                m_count[s] = n;
                set_class(s, CLS_FREE);
            end
            if (s < 0) begin
                r.status = ST_NO_SLAB;
            end else begin
                m_count[s]--;
                r.object_address = m_base + (AddrW'(s) << SlabShift)
                    + AddrW'(m_offsets[s*MaxObjects+m_count[s]]);
                set_class(s, m_count[s] == 0 ? CLS_FULL : CLS_PARTIAL);
            end
        end else begin
            if (w.free_address < m_base) begin
                r.status = ST_BAD;
            end else begin
                rel = w.free_address - m_base;
                idx = rel >> SlabShift;
                off = rel & ((64'd1 << SlabShift) - 1);
                if (!(idx < m_grown && m_class[idx] != CLS_UNUSED
                      && off < longint'(n) * m_obj_bytes)) begin
                    r.status = ST_BAD;
                end else if (m_count[idx] >= n) begin
                    r.status = ST_DOUBLE;
                end else begin
                    m_offsets[idx*MaxObjects+m_count[idx]] = off[15:0];
                    m_count[idx]++;
                    set_class(int'(idx), m_count[idx] >= n ? CLS_FREE : CLS_PARTIAL);
                end
            end
        end
        return r;
    endfunction

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_words.size() == 0) begin
                fails++;
                if (mismatches < 10) $display("Unexpected result word %h", result);
                mismatches++;
            end else begin
                t_out_word e;
                e = expected_words.pop_front();
                if (result.object_address !== e.object_address
                    || result.status !== e.status) begin
                    fails++;
                    if (mismatches < 10) begin
                        $display("Mismatch: expected addr %h status %0d, got addr %h status %0d",
                                 e.object_address, e.status,
                                 result.object_address, result.status);
                    end
                    mismatches++;
                end
                if (e.status == ST_OK && e.object_address != 0 || e.status == ST_OK) begin
                    // Allocations are tracked from the command side.
                end
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 3;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_OBJ_BYTES: m_obj_bytes = val[12:0];
            REG_OBJ_COUNT: m_obj_count = val[6:0];
            REG_BASE:      m_base = val[AddrW-1:0];
            default: ;
        endcase
    endtask

    task automatic quiesce();
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // The start line stays high after an accepted word until the next word
    // replaces the command, so consecutive words go back to back.
    task automatic issue(t_in_word w, logic has_exp, t_out_word exp, logic do_idle);
        t_out_word p;
        if (do_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        p = predict_allocator(w);
        if (has_exp && (p !== exp)) begin
            fails++;
            if (mismatches < 10) $display("Table row disagrees with model: %h vs %h", exp, p);
            mismatches++;
        end
        expected_words.push_back(p);
        if (w.operation == OP_ALLOC && p.status == ST_OK) live_addrs.push_back(p.object_address);
    endtask

    function automatic t_in_word random_word();
        t_in_word w;
        int k;
        logic [AddrW-1:0] a;
        w.operation = 1'($urandom_range(0, 1));
        a = AddrW'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                if (live_addrs.size() > 0) begin
                    k = $urandom_range(0, live_addrs.size() - 1);
                    a = live_addrs[k];
                    live_addrs.delete(k);
                end
            end
            3: a = m_base + (AddrW'($urandom_range(0, MaxSlabs)) << SlabShift)
                   + AddrW'($urandom_range(0, 70000));
            4: a = m_base - AddrW'($urandom_range(1, 4));
            default: ;
        endcase
        w.free_address = a;
        return w;
    endfunction

    t_row rows [$];

    initial begin
        t_row r;
        t_in_word w;
        logic [63:0] cfg_sets [5][3];
        rst_n = 1'b0; start = 1'b0; cmd = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cycles = 0; fails = 0; mismatches = 0;
        for (int s = 0; s < MaxSlabs; s++) begin
            m_count[s] = 0; m_class[s] = CLS_UNUSED; m_stamp[s] = 0;
        end
        m_stamp_ctr = 0; m_grown = 0;
        m_obj_bytes = 64; m_obj_count = 64; m_base = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        r.has_exp = 1'b1;
        r.word = '{OP_FREE, 48'h0};                 r.exp = '{48'h0, ST_BAD};    rows.push_back(r);
        r.word = '{OP_ALLOC, 48'hFFFF_FFFF_FFFF};   r.exp = '{48'hFC0, ST_OK};   rows.push_back(r);
        r.word = '{OP_ALLOC, 48'h0};                r.exp = '{48'hF80, ST_OK};   rows.push_back(r);
        r.word = '{OP_FREE, 48'hFC0};               r.exp = '{48'h0, ST_OK};     rows.push_back(r);
        r.word = '{OP_FREE, 48'hF80};               r.exp = '{48'h0, ST_OK};     rows.push_back(r);
        r.word = '{OP_FREE, 48'hF80};               r.exp = '{48'h0, ST_DOUBLE}; rows.push_back(r);
        r.word = '{OP_FREE, 48'h1000};              r.exp = '{48'h0, ST_BAD};    rows.push_back(r);
        r.word = '{OP_FREE, 48'hFFFF_FFFF_FFFF};    r.exp = '{48'h0, ST_BAD};    rows.push_back(r);
        r.has_exp = 1'b0;
        r.word = '{OP_ALLOC, 48'h0};                                            rows.push_back(r);
        r.word = '{OP_FREE, 48'h0FC1};                                          rows.push_back(r);
        r.word = '{OP_ALLOC, 48'h0};                                            rows.push_back(r);
        foreach (rows[i]) issue(rows[i].word, rows[i].has_exp, rows[i].exp, 1'b0);
        quiesce();

        // Set one object per slab and allocate more times than there are slabs.
        reg_write(REG_OBJ_COUNT, 64'd0);
        reg_write(REG_OBJ_BYTES, 64'd4096);
        for (int i = 0; i < MaxSlabs + 2; i++) begin
            w = '{OP_ALLOC, 48'h0};
            issue(w, 1'b0, '0, 1'b0);
        end
        quiesce();

        cfg_sets[0] = '{64'd1, 64'd64, 64'h0};
        cfg_sets[1] = '{64'd4096, 64'd16, 64'hFFFF_FFFF_0000};
        cfg_sets[2] = '{64'd24, 64'd127, 64'h1234_5678_0000};
        cfg_sets[3] = '{64'd1000, 64'd1, 64'h8000_0000_0000};
        cfg_sets[4] = '{64'd64, 64'd8, 64'h0001_0000};
        for (int p = 0; p < 5; p++) begin
            reg_write(REG_OBJ_BYTES, cfg_sets[p][0]);
            reg_write(REG_OBJ_COUNT, cfg_sets[p][1]);
            reg_write(REG_BASE, cfg_sets[p][2]);
            for (int i = 0; i < 300; i++) begin
                issue(random_word(), 1'b0, '0, p < 4);
            end
            quiesce();
        end

        quiesce();
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
